// ===== rtl/sscr_pkg.sv =====
// shared types and constants for the stepper s-curve ramp sequencer
`timescale 1ns / 1ps

package sscr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int RAMP_LEN_W   = 9;
    localparam int CRUISE_W     = 16;
    localparam int PERIOD_W     = 16;
    localparam int COMPARE_W    = 15;
    localparam int TIDX_W       = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [RAMP_LEN_W-1:0] RAMP_LEN_RESET    = 9'd256;
    localparam logic [CRUISE_W-1:0]   CRUISE_STEPS_RESET = 16'd600;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_LENGTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_STEPS = 1'd1;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    // what one request leaves for the result stage
    typedef struct packed {
        logic   load;
        logic   off;
        phase_t phase;
    } step_info_t;

endpackage

// ===== rtl/sscr_table.sv =====
// period table memory: one write port, one registered read port
`timescale 1ns / 1ps

module sscr_table #(
    parameter int TABLE_DEPTH = sscr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
    input  logic [sscr_pkg::PERIOD_W-1:0]       wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    output logic [sscr_pkg::PERIOD_W-1:0]       rd_data
);
    import sscr_pkg::*;

    logic [PERIOD_W-1:0] mem [TABLE_DEPTH];
    logic [PERIOD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sscr_ctrl.sv =====
// ramp phase sequencer: config registers, move state and table read address
`timescale 1ns / 1ps

module sscr_ctrl #(
    parameter int TABLE_DEPTH = sscr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr,
    input  logic [sscr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sscr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                req_accept,
    input  logic [1:0]                          req_type,
    output logic                                rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    output sscr_pkg::step_info_t                info
);
    import sscr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [RAMP_LEN_W-1:0] ramp_length_reg;
    logic [CRUISE_W-1:0]   cruise_steps_reg;
    phase_t                phase_reg, phase_next;
    logic [CW-1:0]         index_reg, index_next;
    logic [CRUISE_W-1:0]   cruise_reg, cruise_next;
    logic                  parity_reg, parity_next;

    logic [CW-1:0]         used_len;
    logic [CW:0]           index_inc;
    logic [CW-1:0]         rd_idx;
    logic [CW-1:0]         rd_idx_clamped;

    always_comb begin
        if (ramp_length_reg == '0) begin
            used_len = CW'(1);
        end else if (32'(ramp_length_reg) > 32'(TABLE_DEPTH)) begin
            used_len = DEPTH_C;
        end else begin
            used_len = CW'(ramp_length_reg);
        end
    end

    assign index_inc = {1'b0, index_reg} + (CW+1)'(1);

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        cruise_next = cruise_reg;
        parity_next = parity_reg;
        rd_en       = 1'b0;
        rd_idx      = index_reg;
        info.load   = 1'b0;
        info.off    = 1'b0;
        if (req_accept) begin
            if (req_type == REQ_START) begin
                phase_next  = PH_ACCEL;
                index_next  = '0;
                parity_next = 1'b0;
                cruise_next = cruise_steps_reg;
            end else if (req_type == REQ_EVENT) begin
                parity_next = ~parity_reg;
                // only every second compare event is acted on
                if (parity_reg) begin
                    unique case (phase_reg)
                        PH_ACCEL: begin
                            rd_en      = 1'b1;
                            rd_idx     = index_reg;
                            info.load  = 1'b1;
                            index_next = index_inc[CW-1:0];
                            if (index_inc >= {1'b0, used_len}) begin
                                phase_next = PH_CRUISE;
                            end
                        end
                        PH_CRUISE: begin
                            if (cruise_reg <= CRUISE_W'(1)) begin
                                cruise_next = '0;
                                phase_next  = PH_DECEL;
                            end else begin
                                cruise_next = cruise_reg - CRUISE_W'(1);
                            end
                        end
                        PH_DECEL: begin
                            rd_en     = 1'b1;
                            info.load = 1'b1;
                            if (index_reg != '0) begin
                                index_next = index_reg - CW'(1);
                                rd_idx     = index_reg - CW'(1);
                            end else begin
                                rd_idx     = '0;
                            end
                            if (index_reg <= CW'(1)) begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_STOP: begin
                            info.off   = 1'b1;
                            phase_next = PH_ACCEL;
                        end
                        default: begin
                            phase_next = PH_ACCEL;
                        end
                    endcase
                end
            end
        end
        info.phase = phase_next;
    end

    assign rd_idx_clamped = (rd_idx >= DEPTH_C) ? DEPTH_C - CW'(1) : rd_idx;
    assign rd_addr        = rd_idx_clamped[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_length_reg  <= RAMP_LEN_RESET;
            cruise_steps_reg <= CRUISE_STEPS_RESET;
            phase_reg        <= PH_ACCEL;
            index_reg        <= '0;
            cruise_reg       <= CRUISE_STEPS_RESET;
            parity_reg       <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_RAMP_LENGTH:  ramp_length_reg  <= cfg_data[RAMP_LEN_W-1:0];
                    CFG_CRUISE_STEPS: cruise_steps_reg <= cfg_data[CRUISE_W-1:0];
                    default: ;
                endcase
            end
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            cruise_reg <= cruise_next;
            parity_reg <= parity_next;
        end
    end

endmodule

// ===== rtl/stepper_s_curve_ramp_sequencer.sv =====
// top level of the stepper s-curve ramp sequencer
`timescale 1ns / 1ps

// Step-pulse ramp sequencer for one stepper channel. Every request (table
// write, start, compare event) yields exactly one result. Requests are taken
// one per clock cycle unless the result stage is stalled by the output. The
// period table is read at the edge that accepts a compare event; the read
// data and the request's info wait in the result stage, and the output
// register loads from them once the output is free. Move state sits in
// registers next to the table, so a table write is visible to a compare
// event accepted in the very next cycle. The period table has no reset: a
// ramp must only touch entries that were written. Configuration writes are
// taken at any time and are meant for an idle block.

module stepper_s_curve_ramp_sequencer #(
    parameter int TABLE_DEPTH = sscr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sscr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sscr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,  // table_index[7:0], table_value[23:8]
    input  logic [1:0]                         s_tuser,  // req_type[1:0]
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // reload_value[15:0],
                                                         // compare_value[30:16],
                                                         // phase[32:31], zero[39:33]
    output logic [1:0]                         m_tuser   // load_period[0], channel_off[1]
);
    import sscr_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int WIDE_W = (AW > TIDX_W) ? AW : TIDX_W;

    logic                  s_accept;
    logic                  out_free;
    logic                  s1_adv;
    logic [TIDX_W-1:0]     table_index;
    logic [PERIOD_W-1:0]   table_value;
    logic [WIDE_W-1:0]     wr_index_wide;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [PERIOD_W-1:0]   rd_data;
    step_info_t            info;

    logic                  s1_valid_reg;
    step_info_t            s1_info_reg;

    logic                  m_valid_reg;
    logic [PERIOD_W-1:0]   m_reload_reg;
    step_info_t            m_info_reg;
    logic [PERIOD_W-1:0]   reload_sel;

    assign table_index = s_tdata[7:0];
    assign table_value = s_tdata[23:8];

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // table writes beyond the table depth are dropped
    assign wr_index_wide = WIDE_W'(table_index);
    assign wr_en = s_accept && (s_tuser == REQ_WRITE)
                   && (32'(table_index) < 32'(TABLE_DEPTH));

    sscr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_accept (s_accept),
        .req_type   (s_tuser),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .info       (info)
    );

    sscr_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_index_wide[AW-1:0]),
        .wr_data (table_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // quiet results carry a zero period
    assign reload_sel = s1_info_reg.load ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                s1_info_reg  <= info;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg  <= 1'b1;
                m_reload_reg <= reload_sel;
                m_info_reg   <= s1_info_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_info_reg.phase,
                       m_reload_reg[PERIOD_W-1:1], m_reload_reg};
    assign m_tuser  = {m_info_reg.off, m_info_reg.load};

    // end of move always lands back in acceleration without a new period
    a_off_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_info_reg.off |-> m_info_reg.phase == PH_ACCEL && !m_info_reg.load)
        else $error("channel off with wrong phase or period load");

    // results without a period load carry zero values
    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_info_reg.load |-> m_reload_reg == '0)
        else $error("quiet result carries a period");

    // a table read is issued only by an accepted request
    a_read_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> s_accept && s_tuser == REQ_EVENT)
        else $error("table read without accepted compare event");

    // a stalled result stage holds its request
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_info_reg))
        else $error("result stage lost a request under stall");

    // a written table entry is never also read by the same request
    a_no_wr_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("table write and read from one request");

endmodule
